// File: hw/rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int PoolCells = 256;
  localparam int MaxBlocks = 16;
  localparam int CellW = $clog2(PoolCells);
  localparam int CntW = CellW + 1;
  localparam int SlotW = $clog2(MaxBlocks);
  localparam int LenW = 9;
  localparam int AddrW = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_GROW_RD,
    S_GROW_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MARK,
    S_CLEAR,
    S_DONE
  } fsm_t;

endpackage

// File: hw/rtl/first_fit_bitmap_allocator.sv
// Channel   Direction  Handshake            Payload
// in_       input      start high, busy low in_action, in_block_address, in_length
// out_      output     out_valid one cycle  out_status, out_result_address, out_moved
// cfg_      input      cfg_we               cfg_base_address
// After reset the occupancy bitmap is cleared one cell a cycle, all 256 cells, with busy high.
// Allocate goes straight to the decision; free and resize first check the 16 table slots.
// The bitmap scan spends a read state and a check state on each cell, as the occupancy RAM
// output is registered, and marking or clearing takes one cycle a cell.
// Busy falls in the cycle in which out_valid is high. The receiver cannot stall.
module first_fit_bitmap_allocator
  import ffba_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_action,
  input  logic [ffba_pkg::AddrW-1:0] in_block_address,
  input  logic [ffba_pkg::LenW-1:0]  in_length,
  input  logic                    cfg_we,
  input  logic [ffba_pkg::AddrW-1:0] cfg_base_address,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [ffba_pkg::AddrW-1:0] out_result_address,
  output logic                    out_moved
);

  fsm_t state_r, state_nxt;
  logic [AddrW-1:0] base_r;
  logic [1:0] act_r;
  logic [AddrW-1:0] addr_r;
  logic [LenW-1:0] len_r;
  logic [MaxBlocks-1:0] bval_r, bval_nxt;
  logic [CellW-1:0] bstart_r [MaxBlocks];
  logic [LenW-1:0] blen_r [MaxBlocks];
  logic [SlotW:0] sidx_r, sidx_nxt;
  logic hit_r, hit_nxt;
  logic [SlotW-1:0] hslot_r, hslot_nxt;
  logic [CntW-1:0] cell_r, cell_nxt;
  logic [CntW-1:0] end_r, end_nxt;
  logic [CntW-1:0] run_r, run_nxt;
  logic [CntW-1:0] first_r, first_nxt;
  logic [CntW-1:0] need_r, need_nxt;
  logic mark_val_r, mark_val_nxt;
  logic drop_old_r, drop_old_nxt;
  logic [1:0] st_r, st_nxt;
  logic [AddrW-1:0] res_r, res_nxt;
  logic mv_r, mv_nxt;
  logic vld_r;
  logic clr_done_r;

  logic ram_we, ram_wd, ram_rd;
  logic [CellW-1:0] ram_wa, ram_ra;

  logic [SlotW-1:0] free_slot;
  logic any_free;
  logic tab_we;
  logic [SlotW-1:0] tab_slot;
  logic [CellW-1:0] tab_start;
  logic [LenW-1:0] tab_len;

  ffba_ram #(.Width(1), .Depth(PoolCells)) u_occ (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  always_comb begin
    free_slot = '0;
    any_free = 1'b0;
    for (int i = MaxBlocks - 1; i >= 0; i--) begin
      if (!bval_r[i]) begin
        free_slot = SlotW'(i);
        any_free = 1'b1;
      end
    end
  end

  assign busy = (state_r != S_IDLE) || !clr_done_r;

  always_comb begin
    state_nxt = state_r;
    sidx_nxt = sidx_r;
    hit_nxt = hit_r;
    hslot_nxt = hslot_r;
    cell_nxt = cell_r;
    end_nxt = end_r;
    run_nxt = run_r;
    first_nxt = first_r;
    need_nxt = need_r;
    mark_val_nxt = mark_val_r;
    drop_old_nxt = drop_old_r;
    st_nxt = st_r;
    res_nxt = res_r;
    mv_nxt = mv_r;
    bval_nxt = bval_r;
    ram_we = 1'b0;
    ram_wa = cell_r[CellW-1:0];
    ram_wd = 1'b0;
    ram_ra = cell_r[CellW-1:0];
    tab_we = 1'b0;
    tab_slot = hslot_r;
    tab_start = bstart_r[hslot_r];
    tab_len = len_r;
    case (state_r)
      S_IDLE: begin
        if (!clr_done_r) begin
          ram_we = 1'b1;
          ram_wd = 1'b0;
          cell_nxt = cell_r + 1'b1;
        end else if (start) begin
          sidx_nxt = '0;
          hit_nxt = 1'b0;
          st_nxt = ST_OK;
          res_nxt = '0;
          mv_nxt = 1'b0;
          drop_old_nxt = 1'b0;
          if (in_action != ACT_NONE) begin
            state_nxt = (in_action == ACT_ALLOC) ? S_DECIDE : S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        if (bval_r[sidx_r[SlotW-1:0]] &&
            (base_r + AddrW'(bstart_r[sidx_r[SlotW-1:0]])) == addr_r && !hit_r) begin
          hit_nxt = 1'b1;
          hslot_nxt = sidx_r[SlotW-1:0];
        end
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == (SlotW+1)'(MaxBlocks - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (act_r == ACT_FREE) begin
          if (!hit_r) begin
            st_nxt = ST_BADFREE;
          end else begin
            cell_nxt = CntW'(bstart_r[hslot_r]);
            end_nxt = CntW'(bstart_r[hslot_r]) + CntW'(blen_r[hslot_r]);
            bval_nxt[hslot_r] = 1'b0;
            mark_val_nxt = 1'b0;
            state_nxt = S_MARK;
          end
        end else if (act_r == ACT_RESIZE && hit_r) begin
          if (len_r == '0) begin
            st_nxt = ST_NOMEM;
          end else if (len_r == blen_r[hslot_r]) begin
            res_nxt = addr_r;
          end else if (len_r < blen_r[hslot_r]) begin
            res_nxt = addr_r;
            cell_nxt = CntW'(bstart_r[hslot_r]) + CntW'(len_r);
            end_nxt = CntW'(bstart_r[hslot_r]) + CntW'(blen_r[hslot_r]);
            mark_val_nxt = 1'b0;
            tab_we = 1'b1;
            state_nxt = S_MARK;
          end else begin
            cell_nxt = CntW'(bstart_r[hslot_r]) + CntW'(blen_r[hslot_r]);
            need_nxt = CntW'(len_r) - CntW'(blen_r[hslot_r]);
            run_nxt = '0;
            state_nxt = S_GROW_RD;
          end
        end else begin
          if (!any_free) begin
            st_nxt = ST_FULL;
          end else if (len_r == '0 || len_r > LenW'(PoolCells)) begin
            st_nxt = ST_NOMEM;
          end else begin
            cell_nxt = '0;
            run_nxt = '0;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_GROW_RD: begin
        if (run_r == need_r) begin
          first_nxt = cell_r - need_r;
          cell_nxt = cell_r - need_r;
          end_nxt = cell_r;
          mark_val_nxt = 1'b1;
          res_nxt = addr_r;
          tab_we = 1'b1;
          state_nxt = S_MARK;
        end else if (cell_r >= CntW'(PoolCells)) begin
          drop_old_nxt = 1'b1;
          if (!any_free) begin
            st_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cell_nxt = '0;
            run_nxt = '0;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          state_nxt = S_GROW_CHK;
        end
      end
      S_GROW_CHK: begin
        if (ram_rd) begin
          drop_old_nxt = 1'b1;
          if (!any_free) begin
            st_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cell_nxt = '0;
            run_nxt = '0;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          run_nxt = run_r + 1'b1;
          cell_nxt = cell_r + 1'b1;
          state_nxt = S_GROW_RD;
        end
      end
      S_SCAN_RD: begin
        if (cell_r >= CntW'(PoolCells)) begin
          st_nxt = ST_NOMEM;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cell_nxt = cell_r + 1'b1;
        state_nxt = S_SCAN_RD;
        if (ram_rd) begin
          run_nxt = '0;
        end else begin
          if (run_r == '0) begin
            first_nxt = cell_r;
          end
          run_nxt = run_r + 1'b1;
          if (run_r + 1'b1 == CntW'(len_r)) begin
            cell_nxt = (run_r == '0) ? cell_r : first_r;
            end_nxt = cell_r + 1'b1;
            mark_val_nxt = 1'b1;
            res_nxt = base_r + AddrW'((run_r == '0) ? cell_r : first_r);
            tab_we = 1'b1;
            tab_slot = free_slot;
            tab_start = CellW'((run_r == '0) ? cell_r : first_r);
            bval_nxt[free_slot] = 1'b1;
            mv_nxt = drop_old_r;
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (cell_r >= end_r) begin
          if (drop_old_r && mark_val_r) begin
            cell_nxt = CntW'(bstart_r[hslot_r]);
            end_nxt = CntW'(bstart_r[hslot_r]) + CntW'(blen_r[hslot_r]);
            bval_nxt[hslot_r] = 1'b0;
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ram_we = 1'b1;
          ram_wd = mark_val_r;
          cell_nxt = cell_r + 1'b1;
        end
      end
      S_CLEAR: begin
        if (cell_r >= end_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_we = 1'b1;
          ram_wd = 1'b0;
          cell_nxt = cell_r + 1'b1;
        end
      end
      S_DONE: begin
        if (st_r != ST_OK) begin
          res_nxt = '0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r <= '0;
      bval_r <= '0;
      vld_r <= 1'b0;
      clr_done_r <= 1'b0;
      cell_r <= '0;
    end else begin
      state_r <= state_nxt;
      bval_r <= bval_nxt;
      cell_r <= cell_nxt;
      vld_r <= (state_r == S_DONE);
      if (!clr_done_r && cell_r == CntW'(PoolCells - 1)) begin
        clr_done_r <= 1'b1;
      end
      if (cfg_we) begin
        base_r <= cfg_base_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && clr_done_r) begin
      act_r <= in_action;
      addr_r <= in_block_address;
      len_r <= in_length;
    end
    sidx_r <= sidx_nxt;
    hit_r <= hit_nxt;
    hslot_r <= hslot_nxt;
    end_r <= end_nxt;
    run_r <= run_nxt;
    first_r <= first_nxt;
    need_r <= need_nxt;
    mark_val_r <= mark_val_nxt;
    drop_old_r <= drop_old_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    mv_r <= mv_nxt;
    if (tab_we) begin
      bstart_r[tab_slot] <= tab_start;
      blen_r[tab_slot] <= tab_len;
    end
  end

  assign out_valid = vld_r;
  assign out_status = st_r;
  assign out_result_address = res_r;
  assign out_moved = mv_r;

`ifndef SYNTHESIS
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result not strobed");
  a_nomove_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_moved && out_result_address == '0)
    else $error("failed item reports data");
  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> busy) else $error("busy low during work");
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && clr_done_r |-> (state_r == S_MARK || state_r == S_CLEAR))
    else $error("stray bitmap write");
`endif

endmodule

// File: hw/rtl/ffba_ram.sv
module ffba_ram #(
  parameter int Width = 1,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
